/* src/idof_pkg.sv */
// shared types and constants for the interval duplicate and overlap filter
package idof_pkg;

	localparam int POS_W   = 32;
	localparam int SCORE_W = 14;
	localparam int IDX_W   = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NO_OVERLAP  = 1'd1;

	typedef struct packed {
		logic [POS_W-1:0]   start_pos;
		logic [POS_W-1:0]   end_pos;
		logic [SCORE_W-1:0] score;
		logic               skipped_in;
		logic               last_entry;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		logic             kept;
		logic             overflow;
		logic             last_result;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // store the accepted input beat
		logic rd_j;      // read address from the inner counter, else outer
		logic ref_init;  // take the outer entry as reference, start inner loop
		logic run;       // inner loop streaming and compare
		logic i_wb;      // write back the outer entry's skip flag
		logic i_inc;
		logic i_clr;
		logic out_load;  // move one result into the output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_last;
		logic skip_s1;
		logic i_last;
		logic run_done;
		logic out_free;
	} dp_sts_t;

endpackage

/* src/idof_ctrl.sv */
// sequencer for load, pairwise pass and result readout
module idof_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  idof_pkg::dp_sts_t sts,
	output idof_pkg::dp_cmd_t cmd
);
	import idof_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD,
		S_I_RD,
		S_I_CHK,
		S_J_RUN,
		S_I_WB,
		S_O_RD,
		S_O_LD
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != S_LOAD);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load  = accept;
				cmd.i_clr = accept && sts.in_last;
			end
			S_I_RD: begin
			end
			S_I_CHK: begin
				if (sts.i_last) begin
					cmd.i_clr = 1'b1;
				end else if (sts.skip_s1) begin
					cmd.i_inc = 1'b1;
				end else begin
					cmd.ref_init = 1'b1;
				end
			end
			S_J_RUN: begin
				cmd.rd_j = 1'b1;
				cmd.run  = 1'b1;
			end
			S_I_WB: begin
				cmd.i_wb  = 1'b1;
				cmd.i_clr = sts.i_last;
				cmd.i_inc = !sts.i_last;
			end
			S_O_RD: begin
			end
			S_O_LD: begin
				cmd.out_load = sts.out_free;
				cmd.i_inc    = sts.out_free && !sts.i_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept && sts.in_last) state_q <= S_I_RD;
				end
				S_I_RD: state_q <= S_I_CHK;
				S_I_CHK: begin
					if (sts.i_last) state_q <= S_O_RD;
					else if (sts.skip_s1) state_q <= S_I_RD;
					else state_q <= S_J_RUN;
				end
				S_J_RUN: begin
					if (sts.run_done) state_q <= S_I_WB;
				end
				S_I_WB: begin
					state_q <= sts.i_last ? S_O_RD : S_I_RD;
				end
				S_O_RD: state_q <= S_O_LD;
				S_O_LD: begin
					if (sts.out_free) state_q <= sts.i_last ? S_LOAD : S_O_RD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

/* src/idof_dp.sv */
// entry stores, reference interval, compare logic and output register
module idof_dp #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  idof_pkg::in_item_t                in_data,
	output idof_pkg::out_item_t               out_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              cfg_we,
	input  logic [idof_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [idof_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  idof_pkg::dp_cmd_t                 cmd,
	output idof_pkg::dp_sts_t                 sts
);
	import idof_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [POS_W-1:0]   start_mem [MAX_ENTRIES];
	logic [POS_W-1:0]   end_mem   [MAX_ENTRIES];
	logic [SCORE_W-1:0] score_mem [MAX_ENTRIES];
	logic               skip_mem  [MAX_ENTRIES];

	logic               mode_q, noov_q;
	logic [CW-1:0]      cnt_q;
	logic               ovf_q;
	logic [IW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [POS_W-1:0]   lo_q, hi_q;
	logic [SCORE_W-1:0] sci_q;
	logic               refskip_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               v_s1;
	logic [IW-1:0]      idx_s1;
	logic [POS_W-1:0]   start_s1, end_s1;
	logic [SCORE_W-1:0] score_s1;
	logic               skip_s1;

	logic [IW-1:0]      rd_addr;
	logic               live, ovl, hit, brk, issue, i_last;
	logic               we;
	logic [IW-1:0]      wa;
	logic               wd;
	logic               has_room;

	assign rd_addr  = cmd.rd_j ? j_q[IW-1:0] : i_q;
	assign i_last   = (CW'(i_q) == (cnt_q - CW'(1)));
	assign has_room = (cnt_q < CW'(MAX_ENTRIES));

	// compare stage
	always_comb begin
		live = cmd.run && v_s1 && !skip_s1;
		ovl  = !((hi_q < start_s1) || (end_s1 < lo_q));
		hit  = 1'b0;
		brk  = 1'b0;
		if (live) begin
			if (!mode_q) begin
				hit = (start_s1 == lo_q) && (end_s1 == hi_q);
			end else if (ovl) begin
				if (noov_q) begin
					hit = 1'b1;
				end else if (sci_q >= score_s1) begin
					hit = 1'b1;
				end else begin
					brk = 1'b1;
				end
			end
		end
		issue = cmd.run && (j_q != cnt_q) && !brk;
	end

	// single write port of the skip store
	always_comb begin
		we = 1'b0;
		wa = i_q;
		wd = 1'b1;
		priority if (cmd.load) begin
			we = has_room;
			wa = cnt_q[IW-1:0];
			wd = in_data.skipped_in;
		end else if (hit) begin
			we = 1'b1;
			wa = idx_s1;
		end else if (cmd.i_wb) begin
			we = refskip_q;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			start_mem[cnt_q[IW-1:0]] <= in_data.start_pos;
			end_mem[cnt_q[IW-1:0]]   <= in_data.end_pos;
			score_mem[cnt_q[IW-1:0]] <= in_data.score;
		end
		if (we) skip_mem[wa] <= wd;
		start_s1 <= start_mem[rd_addr];
		end_s1   <= end_mem[rd_addr];
		score_s1 <= score_mem[rd_addr];
		skip_s1  <= skip_mem[rd_addr];
		idx_s1   <= rd_addr;
	end

	// reference interval; widens only when overlaps all get deleted
	always_ff @(posedge clk) begin
		if (cmd.ref_init) begin
			lo_q  <= start_s1;
			hi_q  <= end_s1;
			sci_q <= score_s1;
		end else if (live && mode_q && noov_q && ovl) begin
			if (start_s1 < lo_q) lo_q <= start_s1;
			if (hi_q < end_s1) hi_q <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.entry_index <= IDX_W'(i_q);
			out_q.kept        <= !skip_s1;
			out_q.overflow    <= ovf_q;
			out_q.last_result <= i_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			noov_q      <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			refskip_q   <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_FILTER_MODE: mode_q <= cfg_data[0];
					REG_NO_OVERLAP:  noov_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				if (has_room) cnt_q <= cnt_q + CW'(1);
				else ovf_q <= 1'b1;
			end else if (cmd.out_load && i_last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + IW'(1);
			if (cmd.ref_init) begin
				j_q       <= CW'(i_q) + CW'(1);
				refskip_q <= 1'b0;
			end else begin
				if (issue) j_q <= j_q + CW'(1);
				if (live && mode_q && ovl && (noov_q || brk)) refskip_q <= 1'b1;
			end
			v_s1 <= issue;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.in_last  = in_data.last_entry;
	assign sts.skip_s1  = skip_s1;
	assign sts.i_last   = i_last;
	assign sts.run_done = cmd.run && ((j_q == cnt_q) || brk);
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

/* src/interval_duplicate_overlap_filter_core.sv */
// top level of the interval duplicate and overlap filter
// The block collects a set of intervals one input beat per cycle, up to
// MAX_ENTRIES of them; beats past capacity are dropped and the overflow bit
// of every result of that set is raised. The beat with last_entry set ends
// the set and starts the pairwise pass selected by filter_mode (exact
// duplicate removal, or overlap resolution steered by no_overlap_allowed).
// During the pass and the readout, stall on the input stays high. The pass
// walks an outer entry over the set and streams the later entries through
// one compare unit out of entry stores with one read and one write port, one
// comparison per cycle; each outer entry is first read and checked, and a
// skipped one is passed over, else the inner loop runs and the outer entry's
// skip flag is written back. Readout gives one result beat per stored entry
// in load order, reading each entry before loading its beat and waiting while
// out_stall holds the output register. The next set may start loading while
// the final result beat still waits in the output register. Configuration must be
// written by the user only while the block is idle; the block does not enforce it.
module interval_duplicate_overlap_filter_core #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input beats
	input  logic                            in_valid,
	output logic                            in_stall,
	input  idof_pkg::in_item_t              in_data,
	// result beats
	output logic                            out_valid,
	input  logic                            out_stall,
	output idof_pkg::out_item_t             out_data,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [idof_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [idof_pkg::CFG_DATA_W-1:0] cfg_data
);
	import idof_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: load, outer and inner loop, readout
	idof_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry stores, compare unit and output register
	idof_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
